/* hw/rtl/arom_pkg.sv */
// Shared types and constants for the address range offset map.
`timescale 1ns / 1ps
package arom_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W     = 6;
    localparam int DATA_W      = 64;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_SET     = 2'd1,
        CMD_LOOKUP  = 2'd2,
        CMD_REVERSE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_ROT,
        CELL_SHL,
        CELL_SHR,
        CELL_WRITE,
        CELL_CLEAR
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [IDX_W-1:0]    sel;
        logic                we_base;
        logic                we_off;
        logic [DATA_W-1:0]   wbase;
        logic [DATA_W-1:0]   woff;
    } cell_ctrl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_LOCATE,
        ST_PLAN,
        ST_SHIFT,
        ST_WR_LO,
        ST_WR_HI,
        ST_DONE
    } state_t;

endpackage

/* hw/rtl/arom_cell.sv */
// One table entry cell: holds a base and an offset, moves them along the chain.
`timescale 1ns / 1ps
module arom_cell import arom_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [IDX_W-1:0]  cell_idx,
    input  cell_ctrl_t        ctrl,
    input  logic [DATA_W-1:0] left_base,
    input  logic [DATA_W-1:0] left_off,
    input  logic [DATA_W-1:0] right_base,
    input  logic [DATA_W-1:0] right_off,
    output logic [DATA_W-1:0] base,
    output logic [DATA_W-1:0] off
);

    logic [DATA_W-1:0] base_reg, base_next;
    logic [DATA_W-1:0] off_reg, off_next;

    always_comb begin
        base_next = base_reg;
        off_next  = off_reg;
        case (ctrl.op)
            CELL_ROT: begin
                base_next = right_base;
                off_next  = right_off;
            end
            CELL_SHL: begin
                if (cell_idx > ctrl.sel) begin
                    base_next = right_base;
                    off_next  = right_off;
                end
            end
            CELL_SHR: begin
                if (cell_idx > ctrl.sel) begin
                    base_next = left_base;
                    off_next  = left_off;
                end
            end
            CELL_WRITE: begin
                if (cell_idx == ctrl.sel) begin
                    if (ctrl.we_base) base_next = ctrl.wbase;
                    if (ctrl.we_off)  off_next  = ctrl.woff;
                end
            end
            CELL_CLEAR: begin
                base_next = '0;
                off_next  = (cell_idx <= IDX_W'(1)) ? ctrl.woff : '0;
            end
            default: begin
                base_next = base_reg;
                off_next  = off_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
            off_reg  <= '0;
        end else begin
            base_reg <= base_next;
            off_reg  <= off_next;
        end
    end

    assign base = base_reg;
    assign off  = off_reg;

endmodule

/* hw/rtl/address_range_offset_map.sv */
// Top level: range table as a ring of cells with a sequencer over it.
// Clear and refused or empty set go from ST_EXEC straight to ST_DONE and the result register.
// Lookup and reverse lookup pass through ST_SCAN for one full ring rotation before ST_DONE.
// Set rotates in ST_SCAN and ST_LOCATE; ST_SHIFT removes entries or opens 1 to 2.
// One request at a time; the next is accepted while a result waits on m_.
// Reset (synchronous, aresetn low) leaves one range over the space, offset 0.
`timescale 1ns / 1ps
module address_range_offset_map import arom_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic          cfg_addr,
    input  logic [63:0]   cfg_wr_data,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [191:0]  s_tdata,   // addr, length, offset
    input  logic [1:0]    s_tuser,   // cmd
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [199:0]  m_tdata,   // entry_index, range_base, range_offset, range_next, pad
    output logic [1:0]    m_tuser    // found, status
);

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_LIM  = CNT_W'(TABLE_DEPTH);

    state_t state_reg, state_next;

    logic [DATA_W-1:0] init_off_reg, mask_reg;
    logic [CNT_W-1:0]  step_reg, count_reg, lo_cnt_reg, hi_cnt_reg;
    logic [CNT_W-1:0]  lo_reg, shift_cnt_reg;
    logic              shr_reg;
    cmd_t              cmd_reg;
    logic [DATA_W-1:0] addr_reg, len_reg, offs_reg, vend_reg, start_reg;
    logic [DATA_W-1:0] m_base_reg, m_off_reg, l_base_reg, l_off_reg;
    logic [DATA_W-1:0] h_off_reg, h_next_reg, h1_off_reg, h1_next_reg;
    logic              cap_found_reg, cap_status_reg;
    logic [IDX_W-1:0]  cap_idx_reg;
    logic [DATA_W-1:0] cap_base_reg, cap_off_reg, cap_next_reg;
    logic              out_valid_reg;
    logic [199:0]      out_data_reg;
    logic [1:0]        out_user_reg;

    cell_ctrl_t        ctrl;
    logic [DATA_W-1:0] cell_base [TABLE_DEPTH];
    logic [DATA_W-1:0] cell_off  [TABLE_DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
            arom_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .cell_idx   (IDX_W'(gi)),
                .ctrl       (ctrl),
                .left_base  (cell_base[(gi + TABLE_DEPTH - 1) % TABLE_DEPTH]),
                .left_off   (cell_off[(gi + TABLE_DEPTH - 1) % TABLE_DEPTH]),
                .right_base (cell_base[(gi + 1) % TABLE_DEPTH]),
                .right_off  (cell_off[(gi + 1) % TABLE_DEPTH]),
                .base       (cell_base[gi]),
                .off        (cell_off[gi])
            );
        end
    endgenerate

    logic [DATA_W-1:0] in_addr, in_len, in_offs;
    assign in_addr = s_tdata[63:0];
    assign in_len  = s_tdata[127:64];
    assign in_offs = s_tdata[191:128];

    logic [DATA_W:0]   vend_sum;
    logic [DATA_W-1:0] vend_calc;
    assign vend_sum  = {1'b0, addr_reg} + {1'b0, len_reg - 64'd1};
    assign vend_calc = vend_sum[DATA_W] ? '1 : vend_sum[DATA_W-1:0];

    logic set_skip, set_full;
    assign set_skip = (len_reg == '0);
    assign set_full = ((count_reg + CNT_W'(2)) >= FULL_LIM);

    logic [DATA_W-1:0] b0, o0, b1;
    assign b0 = cell_base[0];
    assign o0 = cell_off[0];
    assign b1 = cell_base[1];

    logic              in_count;
    logic [DATA_W-1:0] rv_lo, rv_hi;
    logic              rv_hit;
    assign in_count = (step_reg < count_reg);
    assign rv_lo    = b0 + o0;
    assign rv_hi    = b1 + o0;
    assign rv_hit   = in_count && ((o0 & mask_reg) == '0) && (addr_reg >= rv_lo)
                      && (rv_hi > addr_reg) && ((rv_hi - addr_reg) >= len_reg);

    logic [CNT_W-1:0] shr_sel;
    assign shr_sel = lo_reg + CNT_W'(1) - shift_cnt_reg;

    // Merge and span planning from the captured neighbor entries.
    logic [CNT_W-1:0]  p_lo, p_hi, p_count, p_d;
    logic [DATA_W-1:0] p_start, p_vend, p_pbase, p_poff;
    logic              p_next_lo;
    always_comb begin
        p_next_lo = (l_base_reg != addr_reg);
        p_lo      = p_next_lo ? lo_cnt_reg + CNT_W'(1) : lo_cnt_reg;
        p_pbase   = p_next_lo ? l_base_reg : m_base_reg;
        p_poff    = p_next_lo ? l_off_reg : m_off_reg;
        p_start   = addr_reg;
        if ((addr_reg != '0) && (p_poff == offs_reg)) begin
            p_lo    = p_lo - CNT_W'(1);
            p_start = p_pbase;
        end
        p_vend = vend_reg;
        p_hi   = hi_cnt_reg;
        if ((h_next_reg - 64'd1) == vend_reg) begin
            p_hi = hi_cnt_reg + CNT_W'(1);
            if ((p_hi < count_reg) && (h1_off_reg == offs_reg)) begin
                p_vend = h1_next_reg - 64'd1;
                p_hi   = p_hi + CNT_W'(1);
            end
        end else if (h_off_reg == offs_reg) begin
            p_vend = h_next_reg - 64'd1;
            p_hi   = hi_cnt_reg + CNT_W'(1);
        end
        p_count = p_lo + count_reg + CNT_W'(1) - p_hi;
        p_d     = p_hi - p_lo - CNT_W'(1);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_EXEC;
            ST_EXEC: begin
                if (cmd_reg == CMD_CLEAR) state_next = ST_DONE;
                else if (cmd_reg == CMD_SET && (set_skip || set_full)) state_next = ST_DONE;
                else state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (step_reg == LAST_STEP)
                    state_next = (cmd_reg == CMD_SET) ? ST_LOCATE : ST_DONE;
            end
            ST_LOCATE: if (step_reg == LAST_STEP) state_next = ST_PLAN;
            ST_PLAN:   state_next = ST_SHIFT;
            ST_SHIFT:  if (shift_cnt_reg == '0) state_next = ST_WR_LO;
            ST_WR_LO:  state_next = ST_WR_HI;
            ST_WR_HI:  state_next = ST_DONE;
            ST_DONE:   if (!out_valid_reg || m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl         = '0;
        ctrl.op      = CELL_HOLD;
        ctrl.sel     = lo_reg[IDX_W-1:0];
        s_tready     = (state_reg == ST_IDLE);
        case (state_reg)
            ST_EXEC: begin
                if (cmd_reg == CMD_CLEAR) begin
                    ctrl.op   = CELL_CLEAR;
                    ctrl.woff = init_off_reg;
                end
            end
            ST_SCAN, ST_LOCATE: ctrl.op = CELL_ROT;
            ST_SHIFT: begin
                if (shift_cnt_reg != '0) begin
                    ctrl.op = shr_reg ? CELL_SHR : CELL_SHL;
                    if (shr_reg) ctrl.sel = shr_sel[IDX_W-1:0];
                end
            end
            ST_WR_LO: begin
                ctrl.op      = CELL_WRITE;
                ctrl.we_base = 1'b1;
                ctrl.we_off  = 1'b1;
                ctrl.wbase   = start_reg;
                ctrl.woff    = offs_reg;
            end
            ST_WR_HI: begin
                ctrl.op      = CELL_WRITE;
                ctrl.sel     = lo_reg[IDX_W-1:0] + IDX_W'(1);
                ctrl.we_base = 1'b1;
                ctrl.wbase   = vend_reg + 64'd1;
            end
            default: ctrl.op = CELL_HOLD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            init_off_reg  <= '0;
            mask_reg      <= 64'h8000_0000_0000_0000;
            count_reg     <= CNT_W'(1);
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            shift_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                if (cfg_addr) mask_reg <= cfg_wr_data;
                else          init_off_reg <= cfg_wr_data;
            end
            if (out_valid_reg && m_tready && state_reg != ST_DONE) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg  <= cmd_t'(s_tuser);
                        addr_reg <= in_addr;
                        len_reg  <= in_len;
                        offs_reg <= in_offs;
                    end
                end
                ST_EXEC: begin
                    step_reg       <= '0;
                    lo_cnt_reg     <= '0;
                    hi_cnt_reg     <= '0;
                    vend_reg       <= vend_calc;
                    cap_found_reg  <= 1'b0;
                    cap_idx_reg    <= '0;
                    cap_base_reg   <= '0;
                    cap_off_reg    <= '0;
                    cap_next_reg   <= '0;
                    cap_status_reg <= (cmd_reg == CMD_SET) && !set_skip && set_full;
                    if (cmd_reg == CMD_CLEAR) count_reg <= CNT_W'(1);
                end
                ST_SCAN: begin
                    step_reg <= (step_reg == LAST_STEP) ? '0 : step_reg + CNT_W'(1);
                    case (cmd_reg)
                        CMD_LOOKUP: begin
                            if (in_count && addr_reg >= b0) begin
                                cap_found_reg <= 1'b1;
                                cap_idx_reg   <= step_reg[IDX_W-1:0];
                                cap_base_reg  <= b0;
                                cap_off_reg   <= o0;
                                cap_next_reg  <= b1;
                            end
                        end
                        CMD_REVERSE: begin
                            if (!cap_found_reg && rv_hit) begin
                                cap_found_reg <= 1'b1;
                                cap_idx_reg   <= step_reg[IDX_W-1:0];
                                cap_base_reg  <= b0;
                                cap_off_reg   <= o0;
                                cap_next_reg  <= b1;
                            end
                        end
                        default: begin
                            if (step_reg != '0 && in_count) begin
                                if (b0 <= vend_reg) hi_cnt_reg <= hi_cnt_reg + CNT_W'(1);
                                if (b0 <= addr_reg) lo_cnt_reg <= lo_cnt_reg + CNT_W'(1);
                            end
                        end
                    endcase
                end
                ST_LOCATE: begin
                    step_reg <= (step_reg == LAST_STEP) ? '0 : step_reg + CNT_W'(1);
                    if (step_reg + CNT_W'(1) == lo_cnt_reg) begin
                        m_base_reg <= b0;
                        m_off_reg  <= o0;
                    end
                    if (step_reg == lo_cnt_reg) begin
                        l_base_reg <= b0;
                        l_off_reg  <= o0;
                    end
                    if (step_reg == hi_cnt_reg) begin
                        h_off_reg  <= o0;
                        h_next_reg <= b1;
                    end
                    if (step_reg == hi_cnt_reg + CNT_W'(1)) begin
                        h1_off_reg  <= o0;
                        h1_next_reg <= b1;
                    end
                end
                ST_PLAN: begin
                    lo_reg    <= p_lo;
                    start_reg <= p_start;
                    vend_reg  <= p_vend;
                    if (p_lo + CNT_W'(1) != p_hi) count_reg <= p_count;
                    if (p_lo + CNT_W'(1) == p_hi) begin
                        shift_cnt_reg <= '0;
                        shr_reg       <= 1'b0;
                    end else if (p_hi <= p_lo) begin
                        shift_cnt_reg <= p_lo + CNT_W'(1) - p_hi;
                        shr_reg       <= 1'b1;
                    end else begin
                        shift_cnt_reg <= p_d;
                        shr_reg       <= 1'b0;
                    end
                end
                ST_SHIFT: begin
                    if (shift_cnt_reg != '0) shift_cnt_reg <= shift_cnt_reg - CNT_W'(1);
                end
                ST_WR_HI: begin
                    cap_idx_reg  <= lo_reg[IDX_W-1:0];
                    cap_base_reg <= start_reg;
                    cap_off_reg  <= offs_reg;
                    cap_next_reg <= vend_reg + 64'd1;
                end
                ST_DONE: begin
                    if (!out_valid_reg || m_tready) begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {2'b00, cap_next_reg, cap_off_reg, cap_base_reg,
                                          ENTRY_W'(cap_idx_reg)};
                        out_user_reg  <= {cap_status_reg, cap_found_reg};
                    end
                end
                default: begin
                    step_reg <= step_reg;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

/* test/tb.sv */
// Self-checking testbench for the address range offset map: directed and random requests.
`timescale 1ns / 1ps
module tb;
    import arom_pkg::*;

    typedef struct packed {
        bit        found;
        bit [5:0]  idx;
        bit [63:0] base;
        bit [63:0] off;
        bit [63:0] next;
        bit        status;
    } map_result_t;

    class range_map_scoreboard;
        bit [63:0]   bases [TABLE_DEPTH];
        bit [63:0]   offs [TABLE_DEPTH];
        int          count;
        bit [63:0]   init_off;
        bit [63:0]   spec_mask;
        map_result_t pending_results [$];
        int          errors;
        int          checked;
        int          per_cmd [4];
        int          refused;
        int          rev_hits;

        function new();
            init_off  = '0;
            spec_mask = 64'h8000_0000_0000_0000;
            clear_table();
        endfunction

        function void clear_table();
            foreach (bases[i]) begin
                bases[i] = '0;
                offs[i]  = '0;
            end
            offs[0] = init_off;
            offs[1] = init_off;
            count   = 1;
        endfunction

        function map_result_t apply_set(bit [63:0] start, bit [63:0] size, bit [63:0] off);
            map_result_t r;
            bit [63:0]   vend;
            bit [63:0]   tb_b [TABLE_DEPTH];
            bit [63:0]   tb_o [TABLE_DEPTH];
            int          lo, hi, n, moved;
            r = '0;
            if (size == 0) return r;
            if (count + 2 >= TABLE_DEPTH) begin
                r.status = 1'b1;
                refused++;
                return r;
            end
            n    = count;
            vend = (size - 1 > ~start) ? '1 : start + (size - 1);
            hi = n - 1;
            while (hi > 0 && vend < bases[hi]) hi--;
            lo = hi;
            while (lo > 0 && start < bases[lo]) lo--;
            if (bases[lo] != start) lo++;
            if (start != 0) begin
                if (offs[lo-1] == off) begin
                    lo--;
                    start = bases[lo];
                end
            end
            if (hi < n && bases[hi+1] - 1 == vend) hi++;
            if (hi < n && offs[hi] == off) begin
                vend = bases[hi+1] - 1;
                hi++;
            end
            if (lo + 1 != hi) begin
                moved = n + 1 - hi;
                tb_b = bases;
                tb_o = offs;
                for (int k = 0; k < moved; k++) begin
                    bases[lo+1+k] = tb_b[hi+k];
                    offs[lo+1+k]  = tb_o[hi+k];
                end
                count = lo + moved;
            end
            bases[lo]   = start;
            offs[lo]    = off;
            bases[lo+1] = vend + 1;
            r.idx  = lo[5:0];
            r.base = start;
            r.off  = off;
            r.next = vend + 1;
            return r;
        endfunction

        function map_result_t apply_lookup(bit [63:0] a);
            map_result_t r;
            int          i;
            i = 0;
            while (i + 1 < count && a >= bases[i+1]) i++;
            r = '{1'b1, i[5:0], bases[i], offs[i], bases[i+1], 1'b0};
            return r;
        endfunction

        function map_result_t apply_reverse(bit [63:0] f, bit [63:0] size);
            map_result_t r;
            bit [63:0]   lo_t, hi_t;
            r = '0;
            for (int i = 0; i < count; i++) begin
                if ((offs[i] & spec_mask) != 0) continue;
                lo_t = bases[i] + offs[i];
                if (f < lo_t) continue;
                hi_t = bases[i+1] + offs[i];
                if (hi_t <= f) continue;
                if (hi_t - f < size) continue;
                r = '{1'b1, i[5:0], bases[i], offs[i], bases[i+1], 1'b0};
                rev_hits++;
                return r;
            end
            return r;
        endfunction

        function void note_request(cmd_t c, bit [63:0] a, bit [63:0] l, bit [63:0] o);
            map_result_t r;
            per_cmd[c]++;
            case (c)
                CMD_CLEAR: begin
                    clear_table();
                    r = '0;
                end
                CMD_SET:    r = apply_set(a, l, o);
                CMD_LOOKUP: r = apply_lookup(a);
                default:    r = apply_reverse(a, l);
            endcase
            pending_results.push_back(r);
        endfunction

        function void check_result(map_result_t got);
            map_result_t exp;
            checked++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            exp = pending_results.pop_front();
            if (got.found != exp.found) report("found", exp.found, got.found);
            if (got.idx != exp.idx) report("entry_index", exp.idx, got.idx);
            if (got.base != exp.base) report("range_base", exp.base, got.base);
            if (got.off != exp.off) report("range_offset", exp.off, got.off);
            if (got.next != exp.next) report("range_next", exp.next, got.next);
            if (got.status != exp.status) report("status", exp.status, got.status);
        endfunction

        function void report(string field, bit [63:0] e, bit [63:0] g);
            $display("%0t: %s mismatch expected %h actual %h", $time, field, e, g);
            errors++;
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         cfg_wr_en;
    logic         cfg_addr;
    logic [63:0]  cfg_wr_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [199:0] m_tdata;
    logic [1:0]   m_tuser;

    range_map_scoreboard sb;
    bit quiet;
    int hold_left;
    int idle_left;

    address_range_offset_map uut (.*);

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    initial begin
        #40_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        m_tready  = 1'b0;
        idle_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else begin
                if (!quiet && idle_left == 0 && $urandom_range(0, 5) == 0)
                    idle_left = $urandom_range(1, 3);
                if (idle_left > 0) begin
                    m_tready = 1'b0;
                    idle_left--;
                end else begin
                    m_tready = 1'b1;
                end
            end
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_result('{m_tuser[0], m_tdata[5:0], m_tdata[69:6], m_tdata[133:70],
                                  m_tdata[197:134], m_tuser[1]});
        end
    end

    task automatic send_request(cmd_t c, bit [63:0] a, bit [63:0] l, bit [63:0] o);
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = c;
        s_tdata  = {o, l, a};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(c, a, l, o);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (250) @(posedge aclk);
    endtask

    task automatic write_reg(bit idx, bit [63:0] val);
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_addr    = idx;
        cfg_wr_data = val;
        if (idx == 1'b0) sb.init_off = val;
        else sb.spec_mask = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic bit [63:0] pick_addr();
        int i;
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 4095);
            1: return '1 - $urandom_range(0, 300);
            2: return rand64();
            default: begin
                i = $urandom_range(0, sb.count);
                return sb.bases[i] + $urandom_range(0, 40) - 20;
            end
        endcase
    endfunction

    function automatic bit [63:0] pick_len();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return rand64();
            2: return '1 - $urandom_range(0, 3);
            default: return $urandom_range(1, 700);
        endcase
    endfunction

    function automatic bit [63:0] pick_off();
        case ($urandom_range(0, 5))
            0: return rand64();
            1: return 64'h8000_0000_0000_0000 | $urandom_range(0, 3);
            2: return sb.init_off;
            default: return $urandom_range(0, 3);
        endcase
    endfunction

    task automatic random_request(bit with_clear);
        int        w, i;
        bit [63:0] a;
        w = $urandom_range(0, 99);
        if (w < 3 && with_clear) begin
            send_request(CMD_CLEAR, rand64(), rand64(), rand64());
        end else if (w < 45) begin
            send_request(CMD_SET, pick_addr(), pick_len(), pick_off());
        end else if (w < 72) begin
            send_request(CMD_LOOKUP, pick_addr(), rand64(), rand64());
        end else begin
            i = $urandom_range(0, sb.count - 1);
            a = ($urandom_range(0, 4) == 0) ? rand64()
                : sb.bases[i] + sb.offs[i] + $urandom_range(0, 30) - 5;
            send_request(CMD_REVERSE, a, pick_len(), rand64());
        end
    endtask

    initial begin
        bit [63:0] settings [5][2];
        sb          = new();
        quiet       = 1'b0;
        hold_left   = 0;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = CMD_CLEAR;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_request(CMD_LOOKUP, '0, '0, '0);
        send_request(CMD_LOOKUP, '1, '1, '1);
        send_request(CMD_SET, 64'h100, '0, 64'h5);
        send_request(CMD_SET, 64'h0, 64'h10, 64'h5);
        send_request(CMD_SET, 64'h10, 64'h10, 64'h5);
        send_request(CMD_SET, 64'h8, 64'h4, 64'h7);
        send_request(CMD_SET, 64'h8, 64'h4, 64'h5);
        send_request(CMD_SET, '1 - 3, 64'd100, '1);
        send_request(CMD_SET, 64'h1000, 64'h20, 64'h8000_0000_0000_0001);
        send_request(CMD_LOOKUP, 64'h9, '0, '0);
        send_request(CMD_LOOKUP, '1, '0, '0);
        send_request(CMD_REVERSE, 64'h6, 64'h4, '0);
        send_request(CMD_REVERSE, 64'h1005, 64'h1, '0);
        send_request(CMD_REVERSE, 64'h2, '1, '0);
        send_request(CMD_REVERSE, 64'h40, 64'h10, '0);
        send_request(CMD_SET, '0, '1, 64'h3);
        send_request(CMD_LOOKUP, 64'h1234, '0, '0);
        send_request(CMD_CLEAR, '1, '1, '1);
        for (int k = 0; k < 34; k++)
            send_request(CMD_SET, k * 64'h1000 + 64'h10, 64'h80, 64'd1000 + k);
        send_request(CMD_LOOKUP, 64'h5020, '0, '0);
        drain();

        settings[0] = '{64'h0, 64'h8000_0000_0000_0000};
        settings[1] = '{'1, 64'h0};
        settings[2] = '{64'h0000_0000_0000_0003, '1};
        settings[3] = '{rand64(), 64'h0000_0000_0000_0002};
        settings[4] = '{64'h8000_0000_0000_0000, rand64()};
        for (int p = 0; p < 5; p++) begin
            write_reg(1'b0, settings[p][0]);
            write_reg(1'b1, settings[p][1]);
            send_request(CMD_CLEAR, '0, '0, '0);
            if (p == 2) hold_left = 3000;
            if (p == 4) quiet = 1'b1;
            for (int k = 0; k < 360; k++) random_request(p != 3);
            drain();
        end

        $display("Checked %0d results: %0d clear, %0d set (%0d refused), %0d lookup,",
                 sb.checked, sb.per_cmd[CMD_CLEAR], sb.per_cmd[CMD_SET], sb.refused,
                 sb.per_cmd[CMD_LOOKUP]);
        $display("%0d reverse lookup (%0d hits) over five register settings.",
                 sb.per_cmd[CMD_REVERSE], sb.rev_hits);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
